>>> hdl/dofc_pkg.sv
// dofc_pkg: shared types and constants for the disk obstacle fluid coupling block
// payload structs, controller command and status structs, state and register codes
// no dependencies
package dofc_pkg;

  // fixed field widths
  localparam int VEL_BITS     = 24;
  localparam int MAX_GRID_DEF = 256;
  localparam int CELL_W       = 9;
  localparam int SUM_W        = 40;
  localparam int CNT_W        = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_GAIN = 3'd4;

  // pass codes
  localparam logic FUNC_APPLY  = 1'b0;
  localparam logic FUNC_GATHER = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [CELL_W-1:0]          cell_x;
    logic [CELL_W-1:0]          cell_y;
    logic signed [VEL_BITS-1:0] vel_u;
    logic signed [VEL_BITS-1:0] vel_v;
    logic                       last_cell;
  } dofc_in_t;

  typedef struct packed {
    logic signed [VEL_BITS-1:0] out_u;
    logic signed [VEL_BITS-1:0] out_v;
    logic                       inside_res;
    logic signed [VEL_BITS-1:0] disk_vx;
    logic signed [VEL_BITS-1:0] disk_vy;
    logic                       updated;
  } dofc_out_t;

  typedef struct packed {
    logic load_item;
    logic square;
    logic eval;
    logic div_start;
    logic div_sel;
    logic latch_avg_u;
    logic latch_avg_v;
    logic mul;
    logic adjust;
    logic load_out;
  } dofc_cmd_t;

  typedef struct packed {
    logic need_update;
    logic div_done;
  } dofc_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_EVAL,
    ST_DIV_U,
    ST_DIV_V,
    ST_MUL,
    ST_ADJUST,
    ST_OUT
  } dofc_state_t;

endpackage

>>> hdl/disk_obstacle_fluid_coupling.sv
// disk_obstacle_fluid_coupling: top level of the disk obstacle fluid coupling block
// depends on dofc_pkg, dofc_ctrl, dofc_datapath (with dofc_divider)
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_data   (dofc_in_t)
//   out      output     out_valid / out_stall  out_data  (dofc_out_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a cell transaction goes through accept, square, compare and accumulate, and output load
// the last cell of a gather pass with inside cells then averages both sums on the bit-serial
//   divider, one after the other, and then multiplies and adjusts the disk velocity
// synchronous reset clears state, sums and velocity and sets grid_size to 256
// a new transaction is accepted while the previous result still waits under out_stall
module disk_obstacle_fluid_coupling #(
  parameter int MAX_GRID = dofc_pkg::MAX_GRID_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dofc_pkg::dofc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dofc_pkg::dofc_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dofc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dofc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dofc_pkg::*;

  dofc_cmd_t    cmd;
  dofc_status_t status;
  logic         cfg_we;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  dofc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dofc_datapath #(
    .MAX_GRID(MAX_GRID)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> hdl/dofc_divider.sv
// dofc_divider: bit-serial restoring divider for unsigned magnitudes
// one quotient bit per cycle; done pulses when the quotient is complete
// no dependencies
module dofc_divider #(
  parameter int DW = 40,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic          fits;

  // trial subtraction for the next bit
  always_comb begin
    trial = {rem, quo[DW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[VW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> hdl/dofc_datapath.sv
// dofc_datapath: configuration registers, inside test, sums, disk velocity update
// depends on dofc_pkg and dofc_divider; steered by dofc_ctrl commands
module dofc_datapath #(
  parameter int MAX_GRID = dofc_pkg::MAX_GRID_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dofc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dofc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  dofc_pkg::dofc_in_t                 in_data,
  input  dofc_pkg::dofc_cmd_t                cmd,
  output dofc_pkg::dofc_status_t             status,
  output dofc_pkg::dofc_out_t                out_data
);
  import dofc_pkg::*;

  localparam int V  = VEL_BITS;
  localparam int GB = $clog2(MAX_GRID + 1);
  localparam int NW = (GB > CELL_W) ? GB : CELL_W;
  localparam logic [SUM_W-1:0] MAG_HI = SUM_W'((64'd1 << (V - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] MAG_LO = MAG_HI + 1'b1;
  localparam logic signed [V-1:0] VEL_HI = {1'b0, {(V - 1){1'b1}}};
  localparam logic signed [V-1:0] VEL_LO = {1'b1, {(V - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W - 1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
    logic signed [SUM_W-1:0] r;
    if (x[SUM_W] != x[SUM_W-1]) begin
      r = x[SUM_W] ? SUM_LO : SUM_HI;
    end else begin
      r = x[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [V-1:0] sat_vel(input logic signed [V+3:0] x);
    logic signed [V-1:0] r;
    if ((&x[V+3:V-1]) || !(|x[V+3:V-1])) begin
      r = x[V-1:0];
    end else begin
      r = x[V+3] ? VEL_LO : VEL_HI;
    end
    return r;
  endfunction

  // configuration registers
  logic [15:0]       center_x;
  logic [15:0]       center_y;
  logic [7:0]        radius;
  logic [CELL_W-1:0] grid_size;
  logic [15:0]       coupling_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius        <= '0;
      grid_size     <= CELL_W'(256);
      coupling_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:      center_x      <= cfg_data;
        REG_CENTER_Y:      center_y      <= cfg_data;
        REG_RADIUS:        radius        <= cfg_data[7:0];
        REG_GRID_SIZE:     grid_size     <= cfg_data[CELL_W-1:0];
        REG_COUPLING_GAIN: coupling_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured transaction
  dofc_in_t item;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  // distance squares and index range
  logic [17:0]       dx_full;
  logic [17:0]       dy_full;
  logic [17:0]       dx_neg;
  logic [17:0]       dy_neg;
  logic [15:0]       dx_abs;
  logic [15:0]       dy_abs;
  logic [NW-1:0]     grid_ext;
  logic [NW-1:0]     grid_n;
  logic [NW-1:0]     cx_ext;
  logic [NW-1:0]     cy_ext;
  logic              range_ok;
  logic [31:0]       dx_sq;
  logic [31:0]       dy_sq;
  logic [29:0]       r_sq;
  logic              in_range;

  always_comb begin
    dx_full  = {2'b00, item.cell_x, 7'b0} - {2'b00, center_x};
    dy_full  = {2'b00, item.cell_y, 7'b0} - {2'b00, center_y};
    dx_neg   = ~dx_full + 1'b1;
    dy_neg   = ~dy_full + 1'b1;
    dx_abs   = dx_full[17] ? dx_neg[15:0] : dx_full[15:0];
    dy_abs   = dy_full[17] ? dy_neg[15:0] : dy_full[15:0];
    grid_ext = NW'(grid_size);
    grid_n   = (grid_ext > NW'(MAX_GRID)) ? NW'(MAX_GRID) : grid_ext;
    cx_ext   = NW'(item.cell_x);
    cy_ext   = NW'(item.cell_y);
    range_ok = (cx_ext != '0) && (cx_ext <= grid_n) && (cy_ext != '0) && (cy_ext <= grid_n);
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      dx_sq    <= dx_abs * dx_abs;
      dy_sq    <= dy_abs * dy_abs;
      r_sq     <= {16'(radius) * 16'(radius), 14'b0};
      in_range <= range_ok;
    end
  end

  // inside decision and accumulation
  logic signed [SUM_W-1:0] sum_u;
  logic signed [SUM_W-1:0] sum_v;
  logic [CNT_W-1:0]        inside_count;
  logic signed [V-1:0]     vel_x;
  logic signed [V-1:0]     vel_y;
  logic [32:0]             dist_sq;
  logic                    cell_in;
  logic                    gather;
  logic signed [SUM_W:0]   sum_u_add;
  logic signed [SUM_W:0]   sum_v_add;
  logic [CNT_W-1:0]        count_after;
  logic                    need_update;

  always_comb begin
    dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
    cell_in   = in_range && (dist_sq < {3'b000, r_sq});
    gather    = item.func == FUNC_GATHER;
    sum_u_add = $signed({sum_u[SUM_W-1], sum_u})
              + $signed({{(SUM_W + 1 - V){item.vel_u[V-1]}}, item.vel_u});
    sum_v_add = $signed({sum_v[SUM_W-1], sum_v})
              + $signed({{(SUM_W + 1 - V){item.vel_v[V-1]}}, item.vel_v});
    count_after = inside_count;
    if (gather && cell_in && (inside_count != CNT_MAX)) begin
      count_after = inside_count + 1'b1;
    end
    need_update = gather && item.last_cell && (count_after != '0);
  end

  // divider operand selection, magnitude of the chosen sum
  // the first divide starts in the evaluate cycle, so it takes this cell's sum and count
  logic signed [SUM_W-1:0] sum_u_next;
  logic [CNT_W-1:0]        div_cnt;
  logic signed [SUM_W-1:0] div_sum;
  logic [SUM_W-1:0]        div_neg_sum;
  logic [SUM_W-1:0]        div_mag;
  logic [SUM_W-1:0]        quo;
  logic [SUM_W-1:0]        quo_neg;
  logic                    div_done;
  logic                    div_neg;
  logic signed [V-1:0]     avg_sat;

  always_comb begin
    sum_u_next  = (cmd.eval && gather && cell_in) ? sat_sum(sum_u_add) : sum_u;
    div_cnt     = cmd.eval ? count_after : inside_count;
    div_sum     = cmd.div_sel ? sum_v : sum_u_next;
    div_neg_sum = ~div_sum + 1'b1;
    div_mag     = div_sum[SUM_W-1] ? div_neg_sum : div_sum;
    quo_neg     = ~quo + 1'b1;
    if (!div_neg) begin
      avg_sat = (quo > MAG_HI) ? VEL_HI : quo[V-1:0];
    end else begin
      avg_sat = (quo > MAG_LO) ? VEL_LO : quo_neg[V-1:0];
    end
    status.need_update = need_update;
    status.div_done    = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= div_sum[SUM_W-1];
    end
  end

  dofc_divider #(
    .DW(SUM_W),
    .VW(CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_mag),
    .divisor  (div_cnt),
    .done     (div_done),
    .quotient (quo)
  );

  // pull toward averages
  logic signed [V-1:0]  avg_u;
  logic signed [V-1:0]  avg_v;
  logic signed [V:0]    diff_x;
  logic signed [V:0]    diff_y;
  logic signed [V+17:0] prod_x;
  logic signed [V+17:0] prod_y;
  logic signed [V+18:0] rnd_x;
  logic signed [V+18:0] rnd_y;
  logic signed [V+3:0]  tot_x;
  logic signed [V+3:0]  tot_y;

  always_comb begin
    diff_x = $signed({avg_u[V-1], avg_u}) - $signed({vel_x[V-1], vel_x});
    diff_y = $signed({avg_v[V-1], avg_v}) - $signed({vel_y[V-1], vel_y});
    rnd_x  = $signed({prod_x[V+17], prod_x}) + $signed((V + 19)'(32768));
    rnd_y  = $signed({prod_y[V+17], prod_y}) + $signed((V + 19)'(32768));
    // floor shift by 16 gives round half up
    tot_x  = $signed({{4{vel_x[V-1]}}, vel_x}) + $signed({rnd_x[V+18], rnd_x[V+18:16]});
    tot_y  = $signed({{4{vel_y[V-1]}}, vel_y}) + $signed({rnd_y[V+18], rnd_y[V+18:16]});
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_avg_u) begin
      avg_u <= avg_sat;
    end
    if (cmd.latch_avg_v) begin
      avg_v <= avg_sat;
    end
    if (cmd.mul) begin
      prod_x <= diff_x * $signed({1'b0, coupling_gain});
      prod_y <= diff_y * $signed({1'b0, coupling_gain});
    end
  end

  // sums, count and disk velocity state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_u        <= '0;
      sum_v        <= '0;
      inside_count <= '0;
      vel_x        <= '0;
      vel_y        <= '0;
    end else if (cmd.adjust) begin
      sum_u        <= '0;
      sum_v        <= '0;
      inside_count <= '0;
      vel_x        <= sat_vel(tot_x);
      vel_y        <= sat_vel(tot_y);
    end else if (cmd.eval && gather) begin
      if (item.last_cell && (count_after == '0)) begin
        sum_u        <= '0;
        sum_v        <= '0;
        inside_count <= '0;
      end else if (cell_in) begin
        sum_u        <= sat_sum(sum_u_add);
        sum_v        <= sat_sum(sum_v_add);
        inside_count <= count_after;
      end
    end
  end

  // per-cell result fields
  logic signed [V-1:0] res_u;
  logic signed [V-1:0] res_v;
  logic                res_inside;
  logic                res_updated;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_inside  <= cell_in;
      res_updated <= 1'b0;
      if (!gather && cell_in) begin
        res_u <= vel_x;
        res_v <= vel_y;
      end else begin
        res_u <= item.vel_u;
        res_v <= item.vel_v;
      end
    end else if (cmd.adjust) begin
      res_updated <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.out_u      <= res_u;
      out_data.out_v      <= res_v;
      out_data.inside_res <= res_inside;
      out_data.disk_vx    <= vel_x;
      out_data.disk_vy    <= vel_y;
      out_data.updated    <= res_updated;
    end
  end

endmodule

>>> hdl/dofc_ctrl.sv
// dofc_ctrl: sequencer for one transaction at a time through the datapath
// depends on dofc_pkg; drives dofc_datapath commands and both handshakes
module dofc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  dofc_pkg::dofc_status_t status,
  output dofc_pkg::dofc_cmd_t    cmd
);
  import dofc_pkg::*;

  dofc_state_t state;
  dofc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.need_update) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_U;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV_U: begin
        if (status.div_done) begin
          cmd.latch_avg_u = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel     = 1'b1;
          state_next      = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (status.div_done) begin
          cmd.latch_avg_v = 1'b1;
          state_next      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADJUST;
      end
      ST_ADJUST: begin
        cmd.adjust = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = state != ST_IDLE;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
